>>> hdl/mfb_pkg.sv
// Shared constants and control types of the max flow search unit.
`default_nettype none
package mfb_pkg;

  // Graph size and data widths.
  localparam int MAX_V    = 64;
  localparam int VW       = $clog2(MAX_V);
  localparam int CNT_W    = VW + 1;
  localparam int MAT_AW   = 2 * VW;
  localparam int CAP_BITS = 16;
  localparam int FLOW_W   = 22;
  localparam logic [CAP_BITS-1:0] CAP_MAX  = {CAP_BITS{1'b1}};
  localparam logic [FLOW_W-1:0]   FLOW_MAX = {FLOW_W{1'b1}};

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK   = 2'd2;
  localparam logic [CNT_W-1:0]     VCOUNT_RST = CNT_W'(MAX_V);

  // Input operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic load;
    logic run_start;
    logic init;
    logic pop;
    logic scan_start;
    logic scan;
    logic walk_start;
    logic bott_init;
    logic push_flow;
    logic mat_rd_fwd;
    logic bott_upd;
    logic fwd_wr;
    logic bwd_wr;
    logic out_load;
  } mfb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic bad;
    logic q_empty;
    logic found;
    logic scan_end;
    logic at_src;
    logic out_busy;
  } mfb_sts_t;

endpackage
`default_nettype wire

>>> hdl/max_flow_bfs_augmenting_unit.sv
// Top level of the shortest augmenting path max flow unit.
// Usage: after reset the unit clears its 64 x 64 residual matrix, one entry per cycle, with
// in_ready low; configuration writes are taken at any time. A load request (op 0) writes
// one matrix entry. A run request (op 1) repeats a breadth-first search from the source and
// a path update until no path remains, then returns the total flow. The search scans
// neighbors through the single read port of the matrix RAM, which delivers one entry per
// cycle; each augmenting path then takes two walks back along the parent links, one for
// the bottleneck and one for the residual updates. A result waits in an output register
// while new loads are accepted. A run whose source or sink is out of range, or whose
// source equals its sink, returns zero flow without a search.
`default_nettype none
module max_flow_bfs_augmenting_unit
  import mfb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_op,
  input  wire logic [VW-1:0]        in_from_vertex,
  input  wire logic [VW-1:0]        in_to_vertex,
  input  wire logic [15:0]          in_capacity,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [FLOW_W-1:0]         out_max_flow,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0]    cfg_data
);

  mfb_cmd_t cmd;
  mfb_sts_t sts;

  // Configuration writes are always accepted.
  assign cfg_ready = 1'b1;

  mfb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_op(in_op),
    .in_ready(in_ready), .sts(sts), .cmd(cmd)
  );

  mfb_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_from_vertex(in_from_vertex), .in_to_vertex(in_to_vertex),
    .in_capacity(in_capacity), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_max_flow(out_max_flow)
  );

endmodule
`default_nettype wire

>>> hdl/mfb_ram.sv
// Generic single write port RAM with one registered read port.
`default_nettype none
module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> hdl/mfb_ctrl.sv
// Controller state machine that sequences clearing, loads, searches and path updates.
`default_nettype none
module mfb_ctrl
  import mfb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_op,
  output logic          in_ready,
  input  wire mfb_sts_t sts,
  output mfb_cmd_t      cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_POP   = 4'd3;
  localparam logic [3:0] S_POPW  = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_B0    = 4'd6;
  localparam logic [3:0] S_B1    = 4'd7;
  localparam logic [3:0] S_B2    = 4'd8;
  localparam logic [3:0] S_B3    = 4'd9;
  localparam logic [3:0] S_A0    = 4'd10;
  localparam logic [3:0] S_A1    = 4'd11;
  localparam logic [3:0] S_A2    = 4'd12;
  localparam logic [3:0] S_A3    = 4'd13;
  localparam logic [3:0] S_A4    = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && in_op == OP_LOAD) begin
          cmd.load = 1'b1;
        end else if (accept) begin
          cmd.run_start = 1'b1;
          state_nxt = sts.bad ? S_DONE : S_INIT;
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_POP;
      end
      S_POP: begin
        if (sts.q_empty) begin
          state_nxt = S_DONE;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        cmd.scan_start = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found) begin
          state_nxt = S_B0;
        end else if (sts.scan_end) begin
          state_nxt = S_POP;
        end
      end
      // First walk back along the path: find the bottleneck.
      S_B0: begin
        cmd.walk_start = 1'b1;
        cmd.bott_init  = 1'b1;
        state_nxt = S_B1;
      end
      S_B1: begin
        if (sts.at_src) begin
          state_nxt = S_A0;
        end else begin
          state_nxt = S_B2;
        end
      end
      S_B2: begin
        cmd.mat_rd_fwd = 1'b1;
        state_nxt = S_B3;
      end
      S_B3: begin
        cmd.bott_upd = 1'b1;
        state_nxt = S_B1;
      end
      // Second walk: update forward and backward residuals.
      S_A0: begin
        cmd.walk_start = 1'b1;
        cmd.push_flow  = 1'b1;
        state_nxt = S_A1;
      end
      S_A1: begin
        if (sts.at_src) begin
          state_nxt = S_INIT;
        end else begin
          state_nxt = S_A2;
        end
      end
      S_A2: begin
        cmd.mat_rd_fwd = 1'b1;
        state_nxt = S_A3;
      end
      S_A3: begin
        cmd.fwd_wr = 1'b1;
        state_nxt = S_A4;
      end
      S_A4: begin
        cmd.bwd_wr = 1'b1;
        state_nxt = S_A1;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/mfb_dp.sv
// Datapath: residual matrix, search scratch memories, counters and flow arithmetic.
`default_nettype none
module mfb_dp
  import mfb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mfb_cmd_t             cmd,
  output mfb_sts_t                  sts,
  input  wire logic [VW-1:0]        in_from_vertex,
  input  wire logic [VW-1:0]        in_to_vertex,
  input  wire logic [15:0]          in_capacity,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0]    cfg_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [FLOW_W-1:0]         out_max_flow
);

  // Configuration registers.
  logic [CNT_W-1:0] vcount_r;
  logic [VW-1:0]    src_r, dst_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RST;
      src_r    <= '0;
      dst_r    <= VW'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_VCOUNT: vcount_r <= cfg_data[CNT_W-1:0];
        CFG_SOURCE: src_r    <= cfg_data[VW-1:0];
        CFG_SINK:   dst_r    <= cfg_data[VW-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] n_eff;
  assign n_eff = (vcount_r > CNT_W'(MAX_V)) ? CNT_W'(MAX_V) : vcount_r;

  // Search and walk registers.
  logic [MAT_AW-1:0]   clr_cnt_r;
  logic [CNT_W-1:0]    head_r, tail_r, vi_r;
  logic [VW-1:0]       u_r, pvv_r, w_r, pu_r;
  logic                pv_r;
  logic [MAX_V-1:0]    seen_r;
  logic [CAP_BITS-1:0] bott_r;
  logic [FLOW_W-1:0]   total_r;
  logic                out_valid_r;
  logic [FLOW_W-1:0]   out_flow_r;

  // Memory ports.
  logic                mat_we;
  logic [MAT_AW-1:0]   mat_waddr, mat_raddr;
  logic [CAP_BITS-1:0] mat_wdata, mat_rdata;
  logic                par_we;
  logic [VW-1:0]       par_waddr, par_wdata, par_rdata;
  logic                q_we;
  logic [VW-1:0]       q_waddr, q_wdata, q_rdata;

  mfb_ram #(.WIDTH(CAP_BITS), .DEPTH(MAX_V * MAX_V)) u_mat (
    .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
    .raddr(mat_raddr), .rdata(mat_rdata)
  );
  mfb_ram #(.WIDTH(VW), .DEPTH(MAX_V)) u_par (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(w_r), .rdata(par_rdata)
  );
  mfb_ram #(.WIDTH(VW), .DEPTH(MAX_V)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(head_r[VW-1:0]), .rdata(q_rdata)
  );

  // Scan evaluation of the entry read in the previous cycle.
  logic hit, tail_room;
  assign hit       = cmd.scan && pv_r && !seen_r[pvv_r] && (mat_rdata != '0);
  assign tail_room = (tail_r < CNT_W'(MAX_V));

  // Residual arithmetic.
  logic [CAP_BITS:0] bwd_sum;
  logic [FLOW_W:0]   flow_sum;
  assign bwd_sum  = {1'b0, mat_rdata} + {1'b0, bott_r};
  assign flow_sum = {1'b0, total_r} + (FLOW_W + 1)'(bott_r);

  // Matrix port selection.
  always_comb begin
    mat_we    = 1'b0;
    mat_waddr = clr_cnt_r;
    mat_wdata = '0;
    mat_raddr = {u_r, vi_r[VW-1:0]};
    if (cmd.clr_step) begin
      mat_we = 1'b1;
    end else if (cmd.load) begin
      mat_we    = 1'b1;
      mat_waddr = {in_from_vertex, in_to_vertex};
      mat_wdata = in_capacity[CAP_BITS-1:0];
    end else if (cmd.fwd_wr) begin
      mat_we    = 1'b1;
      mat_waddr = {pu_r, w_r};
      mat_wdata = mat_rdata - bott_r;
    end else if (cmd.bwd_wr) begin
      mat_we    = 1'b1;
      mat_waddr = {w_r, pu_r};
      mat_wdata = (bwd_sum > {1'b0, CAP_MAX}) ? CAP_MAX : bwd_sum[CAP_BITS-1:0];
    end
    if (cmd.mat_rd_fwd) begin
      mat_raddr = {par_rdata, w_r};
    end else if (cmd.fwd_wr) begin
      mat_raddr = {w_r, pu_r};
    end
  end

  // Parent and queue writes.
  always_comb begin
    par_we    = 1'b0;
    par_waddr = src_r;
    par_wdata = src_r;
    q_we      = 1'b0;
    q_waddr   = '0;
    q_wdata   = src_r;
    if (cmd.init) begin
      par_we = 1'b1;
      q_we   = 1'b1;
    end else if (hit) begin
      par_we    = 1'b1;
      par_waddr = pvv_r;
      par_wdata = u_r;
      q_we      = (pvv_r != dst_r) && tail_room;
      q_waddr   = tail_r[VW-1:0];
      q_wdata   = pvv_r;
    end
  end

  // Control registers of the search.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      vi_r        <= '0;
      pv_r        <= 1'b0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.init) begin
        seen_r <= {{(MAX_V-1){1'b0}}, 1'b1} << src_r;
        head_r <= '0;
        tail_r <= CNT_W'(1);
      end
      if (cmd.pop) begin
        head_r <= head_r + 1'b1;
      end
      if (cmd.scan_start) begin
        vi_r <= '0;
        pv_r <= 1'b0;
      end else if (cmd.scan) begin
        if (vi_r < n_eff) begin
          pv_r <= 1'b1;
          vi_r <= vi_r + 1'b1;
        end else begin
          pv_r <= 1'b0;
        end
      end
      if (hit) begin
        seen_r[pvv_r] <= 1'b1;
        if (pvv_r != dst_r && tail_room) begin
          tail_r <= tail_r + 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers of the search and the walks.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      u_r <= q_rdata;
    end
    if (cmd.scan) begin
      pvv_r <= vi_r[VW-1:0];
    end
    if (cmd.walk_start) begin
      w_r <= dst_r;
    end else if (cmd.bott_upd || cmd.bwd_wr) begin
      w_r <= pu_r;
    end
    if (cmd.mat_rd_fwd) begin
      pu_r <= par_rdata;
    end
    if (cmd.bott_init) begin
      bott_r <= CAP_MAX;
    end else if (cmd.bott_upd && mat_rdata < bott_r) begin
      bott_r <= mat_rdata;
    end
    if (cmd.run_start) begin
      total_r <= '0;
    end else if (cmd.push_flow) begin
      total_r <= (flow_sum > {1'b0, FLOW_MAX}) ? FLOW_MAX : flow_sum[FLOW_W-1:0];
    end
    if (cmd.out_load) begin
      out_flow_r <= total_r;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.clr_last = &clr_cnt_r;
    sts.bad      = ({1'b0, src_r} >= n_eff) || ({1'b0, dst_r} >= n_eff) || (src_r == dst_r);
    sts.q_empty  = (head_r == tail_r);
    sts.found    = hit && (pvv_r == dst_r);
    sts.scan_end = !pv_r && (vi_r >= n_eff);
    sts.at_src   = (w_r == src_r);
    sts.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid    = out_valid_r;
  assign out_max_flow = out_flow_r;

endmodule
`default_nettype wire

>>> hdl/mfb_checker.sv
// Port level checks of the max flow unit and their binding to the top level.
`default_nettype none
module mfb_checker
  import mfb_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_op,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [FLOW_W-1:0] out_max_flow
);

  // A waiting result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_max_flow))
    else $error("result changed while stalled");

  // The matrix clearing pass keeps the input closed right after reset.
  a_reset_closed: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during clearing");

  // A run request makes the unit busy.
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_RUN |=> !in_ready)
    else $error("input open during a run");

  // A load request leaves the unit ready for the next request.
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_LOAD |=> in_ready)
    else $error("load did not finish in one cycle");

endmodule

bind max_flow_bfs_augmenting_unit mfb_checker u_mfb_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
  .out_valid(out_valid), .out_ready(out_ready), .out_max_flow(out_max_flow)
);
`default_nettype wire
